FILE: src/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, codes and constants for the elevator scan controller.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int FLOORS  = 16;
    localparam int FLOOR_W = 4;
    localparam int CODE_W  = 2;

    typedef logic [FLOORS-1:0]  t_mask;
    typedef logic [FLOOR_W-1:0] t_floor;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_HALL_UP   = 2'd1,
        OP_HALL_DOWN = 2'd2,
        OP_CAR       = 2'd3
    } t_op;

    // car motion state machine
    typedef enum logic [2:0] {
        MOT_STOP = 3'b001,
        MOT_UP   = 3'b010,
        MOT_DOWN = 3'b100
    } t_motion;

    typedef enum logic [1:0] {
        HEAD_NONE = 2'd0,
        HEAD_UP   = 2'd1,
        HEAD_DOWN = 2'd2
    } t_heading;

    localparam logic [CODE_W-1:0] CODE_STOP = 2'd0;
    localparam logic [CODE_W-1:0] CODE_UP   = 2'd1;
    localparam logic [CODE_W-1:0] CODE_DOWN = 2'd2;

    typedef struct packed {
        t_mask    hall_up;
        t_mask    hall_down;
        t_mask    car;
        t_floor   car_floor;
        t_motion  motion;
        t_heading heading;
    } t_car_state;

    function automatic logic [CODE_W-1:0] motion_code(input t_motion m);
        logic [CODE_W-1:0] c;
        case (m)
            MOT_UP:   c = CODE_UP;
            MOT_DOWN: c = CODE_DOWN;
            default:  c = CODE_STOP;
        endcase
        return c;
    endfunction

endpackage

FILE: src/esc_step.sv
// ----------------------------------------------------------------------------
// esc_step
// Next-state logic for one request or one tick of the car state machine.
// ----------------------------------------------------------------------------
module esc_step
    import esc_pkg::*;
(
    input  t_car_state i_state,
    input  t_op        i_op,
    input  t_floor     i_floor,
    output t_car_state o_state,
    output logic       o_arrived,
    output logic       o_idle
);

    t_mask  pend;
    t_mask  here;
    t_mask  req_bit;
    logic   any_pend;
    logic   at_or_above;
    logic   above;
    logic   below;
    logic   at_or_below;
    logic   rev_up;
    logic   rev_down;
    logic   go_up;
    logic   in_range;
    t_mask  n_pend;

    always_comb begin
        pend        = i_state.hall_up | i_state.hall_down | i_state.car;
        any_pend    = |pend;
        here        = t_mask'(1) << i_state.car_floor;
        req_bit     = t_mask'(1) << i_floor;
        in_range    = ({1'b0, i_floor} < (FLOOR_W+1)'(FLOORS));
        at_or_above = |(pend >> i_state.car_floor);
        above       = |((pend >> i_state.car_floor) >> 1);
        below       = |(pend & (here - t_mask'(1)));
        at_or_below = below | (|(pend & here));
        // with nothing pending the turn points sit at the top and bottom floors
        rev_up      = any_pend ? !above : (i_state.car_floor == FLOOR_W'(FLOORS-1));
        rev_down    = any_pend ? !below : (i_state.car_floor == '0);
        go_up       = (i_state.heading == HEAD_DOWN) ? (!at_or_below && at_or_above)
                                                     : at_or_above;

        o_state   = i_state;
        o_arrived = 1'b0;

        if (i_op == OP_TICK) begin
            case (i_state.motion)
                MOT_STOP: begin
                    if (!any_pend) begin
                        o_state.heading = HEAD_NONE;
                    end else if (go_up) begin
                        o_state.motion  = MOT_UP;
                        o_state.heading = HEAD_UP;
                    end else if (at_or_below) begin
                        o_state.motion  = MOT_DOWN;
                        o_state.heading = HEAD_DOWN;
                    end
                end
                MOT_UP: begin
                    if (|((i_state.car | i_state.hall_up) & here)) begin
                        o_state.hall_up = i_state.hall_up & ~here;
                        o_state.car     = i_state.car & ~here;
                        o_state.motion  = MOT_STOP;
                        o_arrived       = 1'b1;
                    end else if (rev_up) begin
                        o_state.motion  = MOT_DOWN;
                        o_state.heading = HEAD_DOWN;
                    end else begin
                        o_state.car_floor = i_state.car_floor + t_floor'(1);
                    end
                end
                MOT_DOWN: begin
                    if (|((i_state.car | i_state.hall_down) & here)) begin
                        o_state.hall_down = i_state.hall_down & ~here;
                        o_state.car       = i_state.car & ~here;
                        o_state.motion    = MOT_STOP;
                        o_arrived         = 1'b1;
                    end else if (rev_down) begin
                        o_state.motion  = MOT_UP;
                        o_state.heading = HEAD_UP;
                    end else begin
                        o_state.car_floor = i_state.car_floor - t_floor'(1);
                    end
                end
                default: begin
                end
            endcase
        end else if (in_range) begin
            case (i_op)
                OP_HALL_UP:   o_state.hall_up   = i_state.hall_up | req_bit;
                OP_HALL_DOWN: o_state.hall_down = i_state.hall_down | req_bit;
                OP_CAR:       o_state.car       = i_state.car | req_bit;
                default: begin
                end
            endcase
        end

        n_pend = o_state.hall_up | o_state.hall_down | o_state.car;
        o_idle = (n_pend == '0);
    end

endmodule

FILE: src/elevator_scan_controller_core.sv
// an accepted request is held in the input register, then its result is written to the result register
// throughput: one item per cycle while the output is not stalled; the car state is updated in a single pass per item
// the input side accepts while a finished result waits, stalling only when both are full
// reset (synchronous, active low): request masks cleared, car at floor 0, stopped,
// no heading; both pipeline stages emptied
// ----------------------------------------------------------------------------
// elevator_scan_controller_core
// Single-car elevator controller: request store and scan state machine.
// ----------------------------------------------------------------------------
module elevator_scan_controller_core
    import esc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic [FLOOR_W-1:0] i_floor,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FLOOR_W-1:0] o_car_floor,
    output logic [CODE_W-1:0]  o_motion,
    output logic [CODE_W-1:0]  o_heading,
    output logic               o_arrived,
    output logic               o_idle
);

    logic               r_s1_valid;
    t_op                r_s1_op;
    t_floor             r_s1_floor;
    t_car_state         r_state;
    t_car_state         n_state;
    logic               r_out_valid;
    logic [FLOOR_W-1:0] r_car_floor;
    logic [CODE_W-1:0]  r_motion;
    logic [CODE_W-1:0]  r_heading;
    logic               r_arrived;
    logic               r_idle;
    logic               n_arrived;
    logic               n_idle;
    logic               advance;
    logic               s1_fire;
    logic               in_fire;

    assign advance = !r_out_valid || !i_out_stall;
    assign s1_fire = r_s1_valid && advance;
    assign o_in_stall = r_s1_valid && !advance;
    assign in_fire = i_in_valid && !o_in_stall;

    esc_step u_step (
        .i_state   (r_state),
        .i_op      (r_s1_op),
        .i_floor   (r_s1_floor),
        .o_state   (n_state),
        .o_arrived (n_arrived),
        .o_idle    (n_idle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_state.hall_up   <= '0;
            r_state.hall_down <= '0;
            r_state.car       <= '0;
            r_state.car_floor <= '0;
            r_state.motion    <= MOT_STOP;
            r_state.heading   <= HEAD_NONE;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (advance) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op    <= t_op'(i_op);
            r_s1_floor <= i_floor;
        end
        if (s1_fire) begin
            r_car_floor <= n_state.car_floor;
            r_motion    <= motion_code(n_state.motion);
            r_heading   <= n_state.heading;
            r_arrived   <= n_arrived;
            r_idle      <= n_idle;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_car_floor = r_car_floor;
    assign o_motion    = r_motion;
    assign o_heading   = r_heading;
    assign o_arrived   = r_arrived;
    assign o_idle      = r_idle;

endmodule

FILE: src/esc_checker.sv
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks on the elevator scan controller, bound to the top level.
// ----------------------------------------------------------------------------
module esc_checker
    import esc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [FLOOR_W-1:0] o_car_floor,
    input logic [CODE_W-1:0]  o_motion,
    input logic [CODE_W-1:0]  o_heading,
    input logic               o_arrived,
    input logic               o_idle
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_car_floor)
            && $stable(o_motion) && $stable(o_heading) && $stable(o_arrived)
            && $stable(o_idle))
        else $error("stalled result changed");

    // input side only backs up when the result register is full and held
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("request stalled with room downstream");

    a_arrive_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_arrived |-> o_motion == CODE_STOP)
        else $error("arrival while car still moving");

    a_move_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_motion != CODE_STOP |-> o_heading == o_motion)
        else $error("moving car with mismatched heading");

    // the car moves at most one floor between consecutive results
    a_one_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) ##1 o_out_valid |->
            (o_car_floor == $past(o_car_floor))
            || (o_car_floor == FLOOR_W'($past(o_car_floor) + FLOOR_W'(1)))
            || (o_car_floor == FLOOR_W'($past(o_car_floor) - FLOOR_W'(1))))
        else $error("car jumped more than one floor");

endmodule

bind elevator_scan_controller_core esc_checker u_esc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_car_floor (o_car_floor),
    .o_motion    (o_motion),
    .o_heading   (o_heading),
    .o_arrived   (o_arrived),
    .o_idle      (o_idle)
);

FILE: tb/sv/elevator_scan_controller_core_tb.sv
// ----------------------------------------------------------------------------
// elevator_scan_controller_core_tb
// Self-checking bench for the elevator scan controller. Hall calls, car
// buttons and ticks go in over the valid/stall request channel. A model of
// the car in the bench predicts floor, motion, heading, arrival and idle
// for every accepted request, and each returned result is checked against
// it. Directed sequences come first, then random traffic under three
// idling mixes.
// ----------------------------------------------------------------------------
module elevator_scan_controller_core_tb;
    import esc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        t_floor            car_floor;
        logic [CODE_W-1:0] motion;
        logic [CODE_W-1:0] heading;
        logic              arrived;
        logic              idle;
    } t_car_report;

    logic   clk;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    t_op    in_op     = OP_TICK;
    t_floor in_floor  = '0;
    logic   out_stall = 1'b0;

    logic              in_stall;
    logic              out_valid;
    t_floor            car_floor;
    logic [CODE_W-1:0] motion;
    logic [CODE_W-1:0] heading;
    logic              arrived;
    logic              idle;

    // model of the car
    t_mask    up_calls    = '0;
    t_mask    down_calls  = '0;
    t_mask    cabin_calls = '0;
    t_floor   car_at      = '0;
    t_motion  car_motion  = MOT_STOP;
    t_heading car_heading = HEAD_NONE;

    t_car_report expected_reports[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int arrivals_seen  = 0;
    int idle_reports   = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    elevator_scan_controller_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_op        (in_op),
        .i_floor     (in_floor),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_car_floor (car_floor),
        .o_motion    (motion),
        .o_heading   (heading),
        .o_arrived   (arrived),
        .o_idle      (idle)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic t_mask pending_calls();
        return up_calls | down_calls | cabin_calls;
    endfunction

    // top floor asked for, or the top of the shaft when nothing is asked
    function automatic t_floor highest_call();
        t_mask waiting;
        waiting = pending_calls();
        for (int f = FLOORS - 1; f >= 0; f--) begin
            if (waiting[f]) return t_floor'(f);
        end
        return t_floor'(FLOORS - 1);
    endfunction

    function automatic t_floor lowest_call();
        t_mask waiting;
        waiting = pending_calls();
        for (int f = 0; f < FLOORS; f++) begin
            if (waiting[f]) return t_floor'(f);
        end
        return '0;
    endfunction

    // car calls always match; hall calls only in the travel direction
    function automatic logic serve_floor(input t_motion dir);
        t_mask here_mask;
        logic  hit;
        here_mask = t_mask'(1) << car_at;
        hit = |(cabin_calls & here_mask);
        if (dir == MOT_UP && |(up_calls & here_mask)) hit = 1'b1;
        if (dir == MOT_DOWN && |(down_calls & here_mask)) hit = 1'b1;
        if (hit) begin
            if (dir == MOT_UP) up_calls &= ~here_mask;
            if (dir == MOT_DOWN) down_calls &= ~here_mask;
            cabin_calls &= ~here_mask;
        end
        return hit;
    endfunction

    function automatic logic advance_car();
        logic served;
        logic above;
        logic below;
        logic go_up;
        served = 1'b0;
        case (car_motion)
            MOT_STOP: begin
                if (pending_calls() == '0) begin
                    car_heading = HEAD_NONE;
                end else begin
                    above = highest_call() >= car_at;
                    below = lowest_call() <= car_at;
                    // heading down keeps going down while anything lies at or below the car
                    go_up = (car_heading == HEAD_DOWN) ? (!below && above) : above;
                    if (go_up) begin
                        car_motion  = MOT_UP;
                        car_heading = HEAD_UP;
                    end else if (below) begin
                        car_motion  = MOT_DOWN;
                        car_heading = HEAD_DOWN;
                    end
                end
            end
            MOT_UP: begin
                if (serve_floor(MOT_UP)) begin
                    served     = 1'b1;
                    car_motion = MOT_STOP;
                end else if (car_at >= highest_call()) begin
                    car_motion  = MOT_DOWN;
                    car_heading = HEAD_DOWN;
                end else begin
                    car_at = car_at + 1'b1;
                end
            end
            MOT_DOWN: begin
                if (serve_floor(MOT_DOWN)) begin
                    served     = 1'b1;
                    car_motion = MOT_STOP;
                end else if (car_at <= lowest_call()) begin
                    car_motion  = MOT_UP;
                    car_heading = HEAD_UP;
                end else begin
                    car_at = car_at - 1'b1;
                end
            end
            default: ;
        endcase
        return served;
    endfunction

    function automatic t_car_report predict_report(input t_op op, input t_floor fl);
        t_car_report r;
        r.arrived = 1'b0;
        if (op == OP_TICK) begin
            r.arrived = advance_car();
        end else if (int'(fl) < FLOORS) begin
            case (op)
                OP_HALL_UP:   up_calls[fl]    = 1'b1;
                OP_HALL_DOWN: down_calls[fl]  = 1'b1;
                default:      cabin_calls[fl] = 1'b1;
            endcase
        end
        r.car_floor = car_at;
        case (car_motion)
            MOT_UP:   r.motion = CODE_UP;
            MOT_DOWN: r.motion = CODE_DOWN;
            default:  r.motion = CODE_STOP;
        endcase
        r.heading = car_heading;
        r.idle    = pending_calls() == '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_car_report want,
                                   input t_car_report got);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("%0t %s: expected floor %0d motion %0d heading %0d arrived %0b idle %0b",
                     $realtime, what, want.car_floor, want.motion, want.heading,
                     want.arrived, want.idle);
            $display("%0t %s:   actual floor %0d motion %0d heading %0d arrived %0b idle %0b",
                     $realtime, what, got.car_floor, got.motion, got.heading,
                     got.arrived, got.idle);
        end
    endtask

    always @(posedge clk) begin : check_results
        t_car_report got;
        t_car_report want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got = '{car_floor, motion, heading, arrived, idle};
                results_seen++;
                if (got.arrived === 1'b1) arrivals_seen++;
                if (got.idle === 1'b1) idle_reports++;
                if (expected_reports.size() == 0) begin
                    report_mismatch("result with nothing outstanding", '0, got);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.car_floor !== want.car_floor || got.motion !== want.motion ||
                        got.heading !== want.heading || got.arrived !== want.arrived ||
                        got.idle !== want.idle) begin
                        report_mismatch("result mismatch", want, got);
                    end
                end
            end
            if (in_valid && !in_stall) begin
                expected_reports.push_back(predict_report(in_op, in_floor));
                requests_sent++;
            end
        end
    end

    always @(posedge clk) begin
        out_stall <= $urandom_range(99) < recv_stall_pct;
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no handshake for %0d cycles", QUIET_LIMIT);
            $display("elevator_scan_controller_core test failed");
            $finish;
        end
    end

    // valid stays high from one request to the next unless the sender idles
    task automatic send_request(input t_op op, input t_floor fl);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_floor <= fl;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // the last request is only queued by the checker at its accepting edge
    task automatic test_drain_pause();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // stopped with nothing pending
        send_request(OP_TICK, 4'd9);
        // arrival going up at the ground floor
        send_request(OP_HALL_UP, 4'd0);
        repeat (2) send_request(OP_TICK, 4'd0);
        // climb to floor 3, reverse at the top call, arrive going down
        send_request(OP_HALL_DOWN, 4'd3);
        repeat (6) send_request(OP_TICK, 4'd15);
        // head down towards an up call, reverse at the lowest call, arrive going up
        send_request(OP_HALL_UP, 4'd1);
        repeat (5) send_request(OP_TICK, 4'd0);
        // extremes of the floor field for every request kind
        send_request(OP_CAR, 4'd15);
        send_request(OP_HALL_DOWN, 4'd15);
        send_request(OP_HALL_UP, 4'd15);
        send_request(OP_CAR, 4'd0);
        send_request(OP_HALL_DOWN, 4'd0);
        send_request(OP_TICK, 4'd0);
    endtask

    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int stall_pct);
        int  tick_pct;
        t_op op;
        tick_pct       = 60;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            // bursts vary between piling up calls and letting the car drain
            if (n % 40 == 0) tick_pct = $urandom_range(95, 30);
            if ($urandom_range(99) < tick_pct) begin
                op = OP_TICK;
            end else begin
                op = t_op'($urandom_range(3, 1));
            end
            send_request(op, t_floor'($urandom_range(FLOORS - 1)));
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_random_traffic(430, 25, 57);
        test_drain_pause();
        test_random_traffic(430, 57, 25);
        test_drain_pause();
        test_random_traffic(440, 0, 0);
        test_drain_pause();
        // allow for anything still inside the two pipeline stages
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        if (expected_reports.size() != 0) begin
            mismatches += expected_reports.size();
            $display("%0d results never arrived", expected_reports.size());
        end
        $display("%0d requests and ticks sent, %0d results checked, %0d mismatches",
                 requests_sent, results_seen, mismatches);
        $display("car arrived %0d times and reported idle %0d times",
                 arrivals_seen, idle_reports);
        if (mismatches == 0) begin
            $display("elevator_scan_controller_core test passed");
        end else begin
            $display("elevator_scan_controller_core test failed");
        end
        $finish;
    end

endmodule
